>>> rtl/urm_pkg.sv
// Shared types, constants and the interrupt priority function for the UART register model.
package urm_pkg;

	localparam int RX_DEPTH = 16;
	localparam int TX_DEPTH = 16;

	localparam int RX_AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
	localparam int TX_AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
	localparam int RX_CW = $clog2(RX_DEPTH + 1);
	localparam int TX_CW = $clog2(TX_DEPTH + 1);

	// item opcodes
	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_LINE  = 2'd2;
	localparam logic [1:0] OP_POP   = 2'd3;

	// register offsets inside the eight-port window
	localparam logic [2:0] REG_RBR = 3'd0;
	localparam logic [2:0] REG_IER = 3'd1;
	localparam logic [2:0] REG_IIR = 3'd2;
	localparam logic [2:0] REG_LCR = 3'd3;
	localparam logic [2:0] REG_MCR = 3'd4;
	localparam logic [2:0] REG_LSR = 3'd5;
	localparam logic [2:0] REG_MSR = 3'd6;
	localparam logic [2:0] REG_SCR = 3'd7;

	// interrupt identification codes
	localparam logic [3:0] IIR_NONE = 4'h1;
	localparam logic [3:0] IIR_TXE  = 4'h2;
	localparam logic [3:0] IIR_RDA  = 4'h4;
	localparam logic [3:0] IIR_RLS  = 4'h6;

	// IER bits
	localparam int IER_RDA  = 0;
	localparam int IER_TXE  = 1;
	localparam int IER_RLS  = 2;

	localparam logic [7:0] LSR_BASE    = 8'h60;
	localparam logic [3:0] IER_MASK    = 4'hF;
	localparam int         LCR_DIV_ACC = 7;
	localparam int         MCR_LBK     = 4;

	// configuration register indexes
	localparam logic [1:0] CFG_BASE = 2'd0;
	localparam logic [1:0] CFG_IRQ  = 2'd1;
	localparam logic [1:0] CFG_PEER = 2'd2;

	localparam logic [15:0] BASE_RST = 16'd1016;
	localparam logic [3:0]  IRQ_RST  = 4'd4;

	typedef struct packed {
		logic [15:0] base_port;
		logic [3:0]  irq_number;
		logic        peer_connected;
	} cfg_t;

	typedef struct packed {
		logic       hit;
		logic [7:0] read_data;
		logic       peer_valid;
		logic [7:0] peer_byte;
		logic       irq_raise;
		logic [3:0] irq_line;
	} result_t;

	typedef struct packed {
		logic [3:0] ident;
		logic       raise;
	} irq_eval_t;

	// Rank line status, then data ready, then THRE.
	function automatic irq_eval_t irq_eval(input logic overrun, input logic rx_any,
			input logic thre, input logic [3:0] ier);
		irq_eval_t r;
		r.raise = 1'b1;
		if (overrun && ier[IER_RLS]) begin
			r.ident = IIR_RLS;
		end else if (rx_any && ier[IER_RDA]) begin
			r.ident = IIR_RDA;
		end else if (thre && ier[IER_TXE]) begin
			r.ident = IIR_TXE;
		end else begin
			r.ident = IIR_NONE;
			r.raise = 1'b0;
		end
		return r;
	endfunction

endpackage

>>> rtl/urm_core.sv
// UART register file state, FIFOs and per-item update logic.
module urm_core import urm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [1:0]  op,
	input  logic [15:0] port,
	input  logic [7:0]  data,
	input  cfg_t        cfg,
	output result_t     res
);

	logic [7:0] rx_mem [RX_DEPTH];
	logic [7:0] tx_mem [TX_DEPTH];

	logic [RX_AW-1:0] rx_head_q, rx_head_d;
	logic [RX_CW-1:0] rx_count_q, rx_count_d;
	logic [TX_AW-1:0] tx_head_q, tx_head_d;
	logic [TX_CW-1:0] tx_count_q, tx_count_d;
	logic [15:0] dl_q, dl_d;
	logic [7:0]  lcr_q, lcr_d, mcr_q, mcr_d, scr_q, scr_d;
	logic [3:0]  ier_q, ier_d, iir_q, iir_d;
	logic        overrun_q, overrun_d, thre_q, thre_d, fifo_on_q, fifo_on_d;

	logic             rx_we, tx_we;
	logic [RX_AW-1:0] rx_wa;
	logic [TX_AW-1:0] tx_wa;
	logic [7:0]       rx_wd, tx_wd;

	logic [RX_CW:0]   rx_sum;
	logic [TX_CW:0]   tx_sum;
	logic [RX_AW-1:0] rx_tail, rx_head_inc;
	logic [TX_AW-1:0] tx_tail, tx_head_inc;
	logic [15:0]      offset;
	logic             in_win, dlab, push_req, thr_wr, need_eval;
	logic [2:0]       reg_sel;
	logic [7:0]       push_byte;
	logic [RX_CW-1:0] rx_cap;
	irq_eval_t        ev_push, ev_main;

	// circular pointers, one compare-subtract wrap
	assign rx_sum = {1'b0, RX_CW'(rx_head_q)} + {1'b0, rx_count_q};
	assign tx_sum = {1'b0, TX_CW'(tx_head_q)} + {1'b0, tx_count_q};
	assign rx_tail = (rx_sum >= (RX_CW+1)'(RX_DEPTH)) ?
		RX_AW'(rx_sum - (RX_CW+1)'(RX_DEPTH)) : RX_AW'(rx_sum);
	assign tx_tail = (tx_sum >= (TX_CW+1)'(TX_DEPTH)) ?
		TX_AW'(tx_sum - (TX_CW+1)'(TX_DEPTH)) : TX_AW'(tx_sum);
	assign rx_head_inc = (rx_head_q == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_head_q + 1'b1;
	assign tx_head_inc = (tx_head_q == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_head_q + 1'b1;

	assign offset  = port - cfg.base_port;
	assign in_win  = (port >= cfg.base_port) && (offset[15:3] == '0);
	assign reg_sel = offset[2:0];
	assign dlab    = lcr_q[LCR_DIV_ACC];
	assign rx_cap  = fifo_on_q ? RX_CW'(RX_DEPTH) : RX_CW'(1);

	always_comb begin
		rx_head_d  = rx_head_q;
		rx_count_d = rx_count_q;
		tx_head_d  = tx_head_q;
		tx_count_d = tx_count_q;
		dl_d       = dl_q;
		lcr_d      = lcr_q;
		mcr_d      = mcr_q;
		scr_d      = scr_q;
		ier_d      = ier_q;
		iir_d      = iir_q;
		overrun_d  = overrun_q;
		thre_d     = thre_q;
		fifo_on_d  = fifo_on_q;
		rx_we      = 1'b0;
		rx_wa      = rx_tail;
		rx_wd      = data;
		tx_we      = 1'b0;
		tx_wa      = tx_tail;
		tx_wd      = data;
		push_req   = 1'b0;
		push_byte  = data;
		thr_wr     = 1'b0;
		need_eval  = 1'b0;
		ev_push    = '0;
		ev_main    = '0;
		res            = '0;
		res.irq_line   = cfg.irq_number;

		case (op)
			OP_READ: begin
				if (in_win) begin
					res.hit = 1'b1;
					if (dlab && reg_sel == REG_RBR) begin
						res.read_data = dl_q[7:0];
					end else if (dlab && reg_sel == REG_IER) begin
						res.read_data = dl_q[15:8];
					end else begin
						unique case (reg_sel)
							REG_RBR: begin
								if (rx_count_q != '0) begin
									res.read_data = rx_mem[rx_head_q];
									rx_head_d  = rx_head_inc;
									rx_count_d = rx_count_q - 1'b1;
									need_eval  = 1'b1;
								end
							end
							REG_IER: res.read_data = {4'h0, ier_q};
							REG_IIR: begin
								res.read_data = {4'h0, iir_q};
								if (iir_q == IIR_TXE) begin
									thre_d    = 1'b0;
									need_eval = 1'b1;
								end
							end
							REG_LCR: res.read_data = lcr_q;
							REG_MCR: res.read_data = mcr_q;
							REG_LSR: begin
								res.read_data = LSR_BASE |
									{6'h0, overrun_q, rx_count_q != '0};
								overrun_d = 1'b0;
								need_eval = 1'b1;
							end
							REG_SCR: res.read_data = scr_q;
							default: res.read_data = '0;
						endcase
					end
				end
			end
			OP_WRITE: begin
				if (in_win) begin
					res.hit = 1'b1;
					if (dlab && reg_sel == REG_RBR) begin
						dl_d = {dl_q[15:8], data};
					end else if (dlab && reg_sel == REG_IER) begin
						dl_d = {data, dl_q[7:0]};
					end else begin
						unique case (reg_sel)
							REG_RBR: begin
								if (tx_count_q < TX_CW'(TX_DEPTH)) begin
									tx_we      = 1'b1;
									tx_count_d = tx_count_q + 1'b1;
								end
								if (mcr_q[MCR_LBK]) begin
									push_req = 1'b1;
								end else if (cfg.peer_connected) begin
									res.peer_valid = 1'b1;
									res.peer_byte  = data;
								end
								thr_wr    = 1'b1;
								need_eval = 1'b1;
							end
							REG_IER: begin
								ier_d = data[3:0] & IER_MASK;
								if (data[IER_TXE]) begin
									thre_d = 1'b1;
								end
								need_eval = 1'b1;
							end
							REG_IIR: begin
								fifo_on_d = data[0];
								if (data[1]) begin
									rx_count_d = '0;
									rx_head_d  = '0;
								end
								if (data[2]) begin
									tx_count_d = '0;
									tx_head_d  = '0;
								end
								need_eval = 1'b1;
							end
							REG_LCR: lcr_d = data;
							REG_MCR: mcr_d = data;
							REG_SCR: scr_d = data;
							default: ;
						endcase
					end
				end
			end
			OP_LINE: push_req = 1'b1;
			default: begin
				if (tx_count_q != '0) begin
					res.hit       = 1'b1;
					res.read_data = tx_mem[tx_head_q];
					tx_head_d     = tx_head_inc;
					tx_count_d    = tx_count_q - 1'b1;
				end
			end
		endcase

		// receive path: line byte or looped-back THR byte
		if (push_req) begin
			if (rx_count_q >= rx_cap) begin
				overrun_d = 1'b1;
			end else begin
				rx_we      = 1'b1;
				rx_wd      = push_byte;
				rx_count_d = rx_count_q + 1'b1;
			end
			ev_push = irq_eval(overrun_d, rx_count_d != '0, thre_q, ier_q);
			iir_d   = ev_push.ident;
			res.irq_raise = ev_push.raise;
		end

		if (thr_wr) begin
			thre_d = 1'b1;
		end

		if (need_eval) begin
			ev_main = irq_eval(overrun_d, rx_count_d != '0, thre_d, ier_d);
			iir_d   = ev_main.ident;
			res.irq_raise = res.irq_raise | ev_main.raise;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_head_q  <= '0;
			rx_count_q <= '0;
			tx_head_q  <= '0;
			tx_count_q <= '0;
			dl_q       <= '0;
			lcr_q      <= '0;
			mcr_q      <= '0;
			scr_q      <= '0;
			ier_q      <= '0;
			iir_q      <= IIR_NONE;
			overrun_q  <= 1'b0;
			thre_q     <= 1'b0;
			fifo_on_q  <= 1'b0;
		end else if (step) begin
			rx_head_q  <= rx_head_d;
			rx_count_q <= rx_count_d;
			tx_head_q  <= tx_head_d;
			tx_count_q <= tx_count_d;
			dl_q       <= dl_d;
			lcr_q      <= lcr_d;
			mcr_q      <= mcr_d;
			scr_q      <= scr_d;
			ier_q      <= ier_d;
			iir_q      <= iir_d;
			overrun_q  <= overrun_d;
			thre_q     <= thre_d;
			fifo_on_q  <= fifo_on_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step && rx_we) begin
			rx_mem[rx_wa] <= rx_wd;
		end
		if (step && tx_we) begin
			tx_mem[tx_wa] <= tx_wd;
		end
	end

	a_rx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rx_count_q <= RX_CW'(RX_DEPTH))
		else $error("rx count beyond depth");

	a_tx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tx_count_q <= TX_CW'(TX_DEPTH))
		else $error("tx count beyond depth");

	a_raise_ident: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.irq_raise |=> iir_q != IIR_NONE)
		else $error("raise without pending cause");

	a_peer_not_loop: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.peer_valid |-> !mcr_q[MCR_LBK] && cfg.peer_connected)
		else $error("peer byte in loopback or without peer");

	a_quiet_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(rx_count_q) && $stable(tx_count_q) && $stable(iir_q))
		else $error("state moved without an item");

endmodule

>>> rtl/uart_register_model_top.sv
// Top level of the UART register model: item channels, config port, pipeline.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one item per beat: op selects
//   bus read, bus write, line byte or transmit-queue pop; port is the I/O
//   address and data the write data or received byte.
//   Output channel (out_valid/out_ready) returns exactly one result beat per
//   item, in order: hit, read_data, peer_valid/peer_byte, irq_raise, irq_line.
//   Configuration (base_port, irq_number, peer_connected) sits on an APB-style
//   port at byte offsets 0, 4 and 8; pready is tied high, reads return values.
// Path: an accepted item lands in the input register, and its result is loaded
//   into the result register once the output side is free, raising out_valid.
// Throughput: one item per cycle when out_ready is high; the whole register-file
//   update is single combinational pass from input register to result register.
// Reset (arst_n low): FIFOs empty, all UART registers zero, IIR reads "none",
//   config returns to base 1016, IRQ 4, no peer; both channels go idle.
// Stall: when out_ready is low the result holds, the input register holds
//   its item, and in_ready drops only once both are occupied.
module uart_register_model_top import urm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// item input
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [15:0] port,
	input  logic [7:0]  data,
	// result output
	output logic        out_valid,
	input  logic        out_ready,
	output logic        hit,
	output logic [7:0]  read_data,
	output logic        peer_valid,
	output logic [7:0]  peer_byte,
	output logic        irq_raise,
	output logic [3:0]  irq_line,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t        cfg_q;
	logic        valid_s1;
	logic [1:0]  op_s1;
	logic [15:0] port_s1;
	logic [7:0]  data_s1;
	logic        out_valid_q;
	result_t     res_q;
	result_t     res_next;
	logic        advance;
	logic        cfg_wr;

	// Move the held item into the result register when that slot frees up.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Hold the item beat while the result side is stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1   <= op;
			port_s1 <= port;
			data_s1 <= data;
		end
	end

	urm_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.op     (op_s1),
		.port   (port_s1),
		.data   (data_s1),
		.cfg    (cfg_q),
		.res    (res_next)
	);

	// Result register: drop the beat once taken, load a new one on advance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_next;
		end
	end

	assign out_valid  = out_valid_q;
	assign hit        = res_q.hit;
	assign read_data  = res_q.read_data;
	assign peer_valid = res_q.peer_valid;
	assign peer_byte  = res_q.peer_byte;
	assign irq_raise  = res_q.irq_raise;
	assign irq_line   = res_q.irq_line;

	// Configuration port: write lands on the access phase; no wait states.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_port      <= BASE_RST;
			cfg_q.irq_number     <= IRQ_RST;
			cfg_q.peer_connected <= 1'b0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				CFG_BASE: cfg_q.base_port      <= pwdata[15:0];
				CFG_IRQ:  cfg_q.irq_number     <= pwdata[3:0];
				CFG_PEER: cfg_q.peer_connected <= pwdata[0];
				default:  ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			CFG_BASE: prdata = {16'h0, cfg_q.base_port};
			CFG_IRQ:  prdata = {28'h0, cfg_q.irq_number};
			CFG_PEER: prdata = {31'h0, cfg_q.peer_connected};
			default:  prdata = '0;
		endcase
	end

endmodule

>>> dv/tb_uart_register_model_top.sv
// Testbench for the UART register model: item driver, result checker, config writes, predictor.
`timescale 1ns / 100ps

module tb_uart_register_model_top;
	import urm_pkg::*;

	// One bus, line or pop request as it sits on the input channel.
	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] port;
		logic [7:0]  data;
	} bus_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;

	logic        in_valid = 1'b0;
	wire         in_ready;
	logic [1:0]  op = OP_READ;
	logic [15:0] port = 16'h0000;
	logic [7:0]  data = 8'h00;

	wire         out_valid;
	logic        out_ready = 1'b0;
	wire         hit;
	wire  [7:0]  read_data;
	wire         peer_valid;
	wire  [7:0]  peer_byte;
	wire         irq_raise;
	wire  [3:0]  irq_line;

	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = 4'h0;
	logic [31:0] pwdata = 32'h0;
	wire  [31:0] prdata;
	wire         pready;

	// Requests waiting for the driver, and results owed by the block, oldest first.
	bus_item_t   backlog[$];
	result_t     due_results[$];

	int          snd_idle_pct = 0;
	int          rcv_idle_pct = 0;
	int          mismatches = 0;
	int          queued = 0;
	logic        long_hold_go = 1'b0;
	logic        long_hold_taken = 1'b0;
	int          hold_left = 0;

	// Shadow copy of the configuration registers.
	logic [15:0] cfg_base;
	logic [3:0]  cfg_irq;
	logic        cfg_peer;

	// Shadow copy of the UART register file.
	logic [7:0]       rx_mem[RX_DEPTH];
	logic [RX_AW-1:0] rx_head;
	logic [RX_CW-1:0] rx_cnt;
	logic [7:0]       tx_mem[TX_DEPTH];
	logic [TX_AW-1:0] tx_head;
	logic [TX_CW-1:0] tx_cnt;
	logic [15:0]      dl_q;
	logic [7:0]       lcr_q;
	logic [7:0]       mcr_q;
	logic [7:0]       scr_q;
	logic [3:0]       ier_q;
	logic [3:0]       iir_q;
	logic             ovr_flag;
	logic             thre_q;
	logic             fifo_en;

	// Per-beat side effects gathered while one request is predicted.
	logic             step_raise;
	logic             step_fwd;
	logic [7:0]       step_fwd_byte;

	uart_register_model_top DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.port       (port),
		.data       (data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.hit        (hit),
		.read_data  (read_data),
		.peer_valid (peer_valid),
		.peer_byte  (peer_byte),
		.irq_raise  (irq_raise),
		.irq_line   (irq_line),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor of the register file
	// ------------------------------------------------------------------

	task automatic uart_state_clear();
		for (int i = 0; i < RX_DEPTH; i++) rx_mem[i] = 8'h00;
		for (int i = 0; i < TX_DEPTH; i++) tx_mem[i] = 8'h00;
		rx_head = '0;
		rx_cnt = '0;
		tx_head = '0;
		tx_cnt = '0;
		dl_q = 16'h0000;
		lcr_q = 8'h00;
		mcr_q = 8'h00;
		scr_q = 8'h00;
		ier_q = 4'h0;
		iir_q = IIR_NONE;
		ovr_flag = 1'b0;
		thre_q = 1'b0;
		fifo_en = 1'b0;
		cfg_base = BASE_RST;
		cfg_irq = IRQ_RST;
		cfg_peer = 1'b0;
	endtask

	// Pick the highest-ranked enabled cause: line status, data ready, THRE.
	task automatic rank_irq();
		if (ovr_flag && ier_q[IER_RLS]) begin
			iir_q = IIR_RLS;
			step_raise = 1'b1;
		end else if (rx_cnt != 0 && ier_q[IER_RDA]) begin
			iir_q = IIR_RDA;
			step_raise = 1'b1;
		end else if (thre_q && ier_q[IER_TXE]) begin
			iir_q = IIR_TXE;
			step_raise = 1'b1;
		end else begin
			iir_q = IIR_NONE;
		end
	endtask

	// Receive one byte; with the FIFO off only a single byte fits.
	task automatic rx_take(input logic [7:0] b);
		logic [RX_CW-1:0] cap;
		logic [RX_AW-1:0] slot;
		cap = fifo_en ? RX_CW'(RX_DEPTH) : RX_CW'(1);
		if (rx_cnt >= cap) begin
			ovr_flag = 1'b1;
		end else begin
			slot = RX_AW'(rx_head + rx_cnt);
			rx_mem[slot] = b;
			rx_cnt = rx_cnt + 1'b1;
		end
		rank_irq();
	endtask

	task automatic read_reg(input logic [2:0] r, output logic [7:0] v);
		v = 8'h00;
		if (lcr_q[LCR_DIV_ACC] && r == REG_RBR) begin
			v = dl_q[7:0];
		end else if (lcr_q[LCR_DIV_ACC] && r == REG_IER) begin
			v = dl_q[15:8];
		end else begin
			case (r)
				REG_RBR: begin
					// an empty receiver reads zero and leaves the interrupt state alone
					if (rx_cnt != 0) begin
						v = rx_mem[rx_head];
						rx_head = rx_head + 1'b1;
						rx_cnt = rx_cnt - 1'b1;
						rank_irq();
					end
				end
				REG_IER: v = {4'h0, ier_q};
				REG_IIR: begin
					v = {4'h0, iir_q};
					if (iir_q == IIR_TXE) begin
						thre_q = 1'b0;
						rank_irq();
					end
				end
				REG_LCR: v = lcr_q;
				REG_MCR: v = mcr_q;
				REG_LSR: begin
					v = LSR_BASE | {6'd0, ovr_flag, (rx_cnt != 0)};
					ovr_flag = 1'b0;
					rank_irq();
				end
				REG_SCR: v = scr_q;
				default: v = 8'h00;
			endcase
		end
	endtask

	task automatic write_reg(input logic [2:0] r, input logic [7:0] v);
		logic [TX_AW-1:0] slot;
		if (lcr_q[LCR_DIV_ACC] && r == REG_RBR) begin
			dl_q[7:0] = v;
		end else if (lcr_q[LCR_DIV_ACC] && r == REG_IER) begin
			dl_q[15:8] = v;
		end else begin
			case (r)
				REG_RBR: begin
					// a full transmit queue drops the byte but still loops or forwards it
					if (tx_cnt < TX_CW'(TX_DEPTH)) begin
						slot = TX_AW'(tx_head + tx_cnt);
						tx_mem[slot] = v;
						tx_cnt = tx_cnt + 1'b1;
					end
					if (mcr_q[MCR_LBK]) begin
						rx_take(v);
					end else if (cfg_peer) begin
						step_fwd = 1'b1;
						step_fwd_byte = v;
					end
					thre_q = 1'b1;
					rank_irq();
				end
				REG_IER: begin
					ier_q = v[3:0] & IER_MASK;
					if (ier_q[IER_TXE]) thre_q = 1'b1;
					rank_irq();
				end
				REG_IIR: begin
					fifo_en = v[0];
					if (v[1]) begin
						rx_cnt = '0;
						rx_head = '0;
					end
					if (v[2]) begin
						tx_cnt = '0;
						tx_head = '0;
					end
					rank_irq();
				end
				REG_LCR: lcr_q = v;
				REG_MCR: mcr_q = v;
				REG_SCR: scr_q = v;
				default: ;
			endcase
		end
	endtask

	task automatic uart_regs_step(input bus_item_t it, output result_t r);
		logic [15:0] off;
		logic [7:0]  v;
		r = '0;
		step_raise = 1'b0;
		step_fwd = 1'b0;
		step_fwd_byte = 8'h00;
		off = it.port - cfg_base;
		case (it.op)
			OP_READ, OP_WRITE: begin
				if (it.port >= cfg_base && off < 16'd8) begin
					r.hit = 1'b1;
					if (it.op == OP_READ) begin
						read_reg(off[2:0], v);
						r.read_data = v;
					end else begin
						write_reg(off[2:0], it.data);
					end
				end
			end
			OP_LINE: rx_take(it.data);
			OP_POP: begin
				if (tx_cnt != 0) begin
					r.hit = 1'b1;
					r.read_data = tx_mem[tx_head];
					tx_head = tx_head + 1'b1;
					tx_cnt = tx_cnt - 1'b1;
				end
			end
			default: ;
		endcase
		r.peer_valid = step_fwd;
		r.peer_byte = step_fwd_byte;
		r.irq_raise = step_raise;
		r.irq_line = cfg_irq;
	endtask

	// ------------------------------------------------------------------
	// Input side: offer the next queued request, predict on each accepted beat
	// ------------------------------------------------------------------
	always @(posedge clk) begin : item_driver
		bus_item_t cur;
		bus_item_t nxt;
		result_t   owed;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				cur.op = op;
				cur.port = port;
				cur.data = data;
				uart_regs_step(cur, owed);
				due_results = {due_results, owed};
			end
			// hold valid and payload until the beat goes through
			if (!in_valid || in_ready) begin
				if (backlog.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
					nxt = backlog[0];
					backlog.delete(0);
					in_valid <= 1'b1;
					op <= nxt.op;
					port <= nxt.port;
					data <= nxt.data;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Output side: random back-pressure, plus one long hold so the block
	// fills up and has to drop in_ready while the sender keeps offering
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (long_hold_go && !long_hold_taken) begin
				long_hold_taken <= 1'b1;
				hold_left <= 400;
				out_ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= rcv_idle_pct);
			end
		end
	end

	// Compare every result beat against the oldest owed result.
	always @(posedge clk) begin : result_checker
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (due_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR %0t: result beat with nothing owed (hit %0d rd %02h)",
						$realtime, hit, read_data);
			end else begin
				want = due_results[0];
				due_results.delete(0);
				if (hit !== want.hit || read_data !== want.read_data ||
						peer_valid !== want.peer_valid || peer_byte !== want.peer_byte ||
						irq_raise !== want.irq_raise || irq_line !== want.irq_line) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("ERROR %0t: result mismatch", $realtime);
						$display("  expected hit %0d rd %02h peer %0d/%02h raise %0d line %0d",
							want.hit, want.read_data, want.peer_valid, want.peer_byte,
							want.irq_raise, want.irq_line);
						$display("  actual   hit %0d rd %02h peer %0d/%02h raise %0d line %0d",
							hit, read_data, peer_valid, peer_byte, irq_raise, irq_line);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Setup cycle, then access cycle; the register takes the value at the access edge.
	task automatic cfg_write(input logic [1:0] idx, input logic [31:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			CFG_BASE: cfg_base = v[15:0];
			CFG_IRQ:  cfg_irq = v[3:0];
			CFG_PEER: cfg_peer = v[0];
			default: ;
		endcase
	endtask

	task automatic put(input logic [1:0] o, input logic [15:0] p, input logic [7:0] d);
		bus_item_t it;
		it.op = o;
		it.port = p;
		it.data = d;
		backlog = {backlog, it};
		queued++;
	endtask

	function automatic logic [15:0] win_port(input logic [2:0] r);
		return cfg_base + {13'd0, r};
	endfunction

	function automatic logic [7:0] any_byte();
		return 8'($urandom_range(255));
	endfunction

	function automatic logic [15:0] any_port();
		return 16'($urandom_range(65535));
	endfunction

	// Keep DLAB mostly clear so the data path stays reachable.
	function automatic logic [7:0] reg_byte(input logic [2:0] r);
		logic [7:0] v;
		v = any_byte();
		if (r == REG_LCR) v[LCR_DIV_ACC] = ($urandom_range(3) == 0);
		return v;
	endfunction

	task automatic put_any();
		int         pick;
		logic [2:0] r;
		pick = $urandom_range(99);
		r = 3'($urandom_range(7));
		if (pick < 8)
			put(2'($urandom_range(3)), any_port(), any_byte());
		else if (pick < 14)
			put($urandom_range(1) ? OP_READ : OP_WRITE,
				$urandom_range(1) ? cfg_base - 16'd1 : cfg_base + 16'd8, any_byte());
		else if (pick < 34)
			put(OP_LINE, any_port(), any_byte());
		else if (pick < 54)
			put(OP_READ, win_port(r), any_byte());
		else if (pick < 84)
			put(OP_WRITE, win_port(r), reg_byte(r));
		else
			put(OP_POP, any_port(), any_byte());
	endtask

	// Mostly bursts that drive the FIFOs to full and back, with scattered noise.
	task automatic queue_random(input int goal);
		int         stop_at;
		logic [2:0] sel;
		stop_at = queued + goal;
		while (queued < stop_at) begin
			case ($urandom_range(9))
				0, 1, 2, 3: put_any();
				4, 5: repeat ($urandom_range(1, 20)) put(OP_LINE, any_port(), any_byte());
				6: begin
					repeat ($urandom_range(1, 20)) begin
						case ($urandom_range(2))
							0: sel = REG_RBR;
							1: sel = REG_LSR;
							default: sel = REG_IIR;
						endcase
						put(OP_READ, win_port(sel), any_byte());
					end
				end
				7: repeat ($urandom_range(1, 20)) put(OP_WRITE, win_port(REG_RBR), any_byte());
				8: repeat ($urandom_range(1, 20)) put(OP_POP, any_port(), any_byte());
				default: begin
					// program the divisor, read it back, drop DLAB
					put(OP_WRITE, win_port(REG_LCR), 8'h80 | any_byte());
					put(OP_WRITE, win_port(REG_RBR), any_byte());
					put(OP_WRITE, win_port(REG_IER), any_byte());
					put(OP_READ, win_port(REG_RBR), any_byte());
					put(OP_READ, win_port(REG_IER), any_byte());
					put(OP_WRITE, win_port(REG_LCR), any_byte() & 8'h7F);
				end
			endcase
		end
	endtask

	task automatic queue_directed();
		put(OP_READ,  win_port(REG_RBR), 8'h00);	// empty receiver
		put(OP_READ,  win_port(REG_IIR), 8'h00);
		put(OP_READ,  win_port(REG_MSR), 8'hFF);
		put(OP_WRITE, win_port(REG_LSR), 8'hFF);	// ignored
		put(OP_WRITE, win_port(REG_MSR), 8'hFF);	// ignored
		put(OP_WRITE, win_port(REG_IER), 8'h0F);	// THRE raise
		put(OP_READ,  win_port(REG_IIR), 8'h00);	// THRE clear
		put(OP_WRITE, win_port(REG_SCR), 8'hFF);
		put(OP_READ,  win_port(REG_SCR), 8'h00);
		put(OP_WRITE, win_port(REG_RBR), 8'h00);	// forwarded to peer
		put(OP_POP,   16'hFFFF, 8'hFF);
		put(OP_POP,   16'h0000, 8'h00);		// empty transmit queue
		put(OP_WRITE, win_port(REG_IIR), 8'h07);	// FIFO on, clear both
		put(OP_LINE,  16'h0000, 8'hFF);
		put(OP_LINE,  16'hFFFF, 8'h00);
		put(OP_WRITE, win_port(REG_IIR), 8'h00);	// FIFO off with two bytes held
		put(OP_LINE,  16'h0000, 8'h5A);		// overrun
		put(OP_READ,  win_port(REG_LSR), 8'h00);
		put(OP_READ,  win_port(REG_RBR), 8'h00);
		put(OP_WRITE, win_port(REG_MCR), 8'h10);	// loopback
		put(OP_WRITE, win_port(REG_RBR), 8'hA5);
		put(OP_WRITE, win_port(REG_LCR), 8'hFF);	// DLAB
		put(OP_WRITE, win_port(REG_RBR), 8'hFF);
		put(OP_READ,  win_port(REG_IER), 8'h00);
		put(OP_WRITE, win_port(REG_LCR), 8'h00);
		put(OP_READ,  cfg_base - 16'd1, 8'h00);	// just below the window
		put(OP_WRITE, cfg_base + 16'd8, 8'hFF);	// just above the window
	endtask

	// Wait until every queued beat went in and every owed result came out.
	task automatic settle();
		int guard;
		guard = 0;
		while ((backlog.size() != 0 || in_valid || due_results.size() != 0) &&
				guard < 50000) begin
			@(negedge clk);
			guard++;
		end
		// let the two-stage pipe drain fully
		repeat (4) @(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		uart_state_clear();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// default window, peer attached: directed checks, then random traffic
		cfg_write(CFG_BASE, 32'd1016);
		cfg_write(CFG_IRQ, 32'd4);
		cfg_write(CFG_PEER, 32'd1);
		@(negedge clk);
		snd_idle_pct = 19;
		rcv_idle_pct = 52;
		queue_directed();
		queue_random(600);
		settle();

		// window at the bottom of the port space, top IRQ number, no peer
		snd_idle_pct = 52;
		rcv_idle_pct = 19;
		cfg_write(CFG_BASE, 32'd0);
		cfg_write(CFG_IRQ, 32'd15);
		cfg_write(CFG_PEER, 32'd0);
		@(negedge clk);
		queue_random(600);
		settle();

		// window at the top, no idling, one long receiver hold to back up the input
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		cfg_write(CFG_BASE, 32'd65528);
		cfg_write(CFG_IRQ, 32'd0);
		cfg_write(CFG_PEER, 32'd1);
		@(negedge clk);
		queue_random(500);
		long_hold_go = 1'b1;
		settle();

		// base at the last port: only the first register stays reachable
		cfg_write(CFG_BASE, 32'd65535);
		cfg_write(CFG_IRQ, 32'd9);
		cfg_write(CFG_PEER, 32'd0);
		@(negedge clk);
		queue_random(100);
		settle();

		if (due_results.size() != 0 || backlog.size() != 0) mismatches++;
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Watchdog: far above the slowest legal run.
	initial begin
		#1500000;
		$display("simulation failed");
		$finish;
	end

endmodule

>>> uart_register_model_top.f
rtl/urm_pkg.sv
rtl/urm_core.sv
rtl/uart_register_model_top.sv
dv/tb_uart_register_model_top.sv
